>>> rtl/core/spm_pkg.sv
`timescale 1ns / 1ps
// spm_pkg: shared types and constants of the sprayer sensor pulse monitor.
// Used by every module of the block; depends on nothing.

package spm_pkg;

	localparam int CntW   = 32;
	localparam int SumW   = CntW + 1;
	localparam int TickW  = 16;
	localparam int CfgW   = 16;
	localparam int AddrW  = 5;
	localparam int DataW  = 32;
	localparam int ProdW  = CntW + CfgW;
	localparam int SpeedW = 24;

	localparam logic [TickW-1:0]  TickSat  = '1;
	localparam logic [SpeedW-1:0] SpeedMax = '1;

	typedef enum logic [2:0] {
		REG_DEBOUNCE    = 3'd0,
		REG_PTO_TIMEOUT = 3'd1,
		REG_PERIOD      = 3'd2,
		REG_LITERS      = 3'd3,
		REG_SPEED_SCALE = 3'd4,
		REG_MOVING_THR  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE        = 3'd0,
		ST_MOVING      = 3'd1,
		ST_SPRAYING    = 3'd2,
		ST_FLOW_FAULT  = 3'd3,
		ST_LEFT_FAULT  = 3'd4,
		ST_RIGHT_FAULT = 3'd5
	} state_t;

	typedef struct packed {
		logic flow_level;
		logic nut_left_level;
		logic nut_right_level;
		logic pto_level;
	} tick_t;

	typedef struct packed {
		logic [47:0] total_liters_q16;
		logic        pto_active;
		logic [31:0] left_count;
		logic [31:0] right_count;
		logic [32:0] count_sum;
		logic [23:0] wheel_speed_q8;
		logic [31:0] flow_in_period;
		state_t      state_code;
	} status_t;

	typedef struct packed {
		logic [CfgW-1:0] debounce_ticks;
		logic [CfgW-1:0] pto_timeout_ticks;
		logic [CfgW-1:0] sample_period_ticks;
		logic [CfgW-1:0] liters_per_pulse_q16;
		logic [CfgW-1:0] speed_scale_q8;
		logic [CfgW-1:0] moving_threshold_q8;
	} cfg_t;

	// snapshot of the counters at a sample tick
	typedef struct packed {
		logic [CntW-1:0] flow_total;
		logic [CntW-1:0] left_total;
		logic [CntW-1:0] right_total;
		logic [SumW-1:0] sum;
		logic [CntW-1:0] dflow;
		logic [CntW-1:0] davg;
		logic            pto;
	} snap_t;

endpackage

>>> rtl/core/spm_regs.sv
`timescale 1ns / 1ps
// spm_regs: APB configuration registers of the pulse monitor.
// Depends on spm_pkg.

module spm_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [spm_pkg::AddrW-1:0] paddr,
	input  logic [spm_pkg::DataW-1:0] pwdata,
	output logic [spm_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output spm_pkg::cfg_t             cfg
);

	spm_pkg::cfg_t            cfg_q;
	logic                     wr_en;
	spm_pkg::reg_idx_t        idx;
	logic [spm_pkg::CfgW-1:0] rd_val;
	logic [spm_pkg::CfgW-1:0] wval;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = spm_pkg::reg_idx_t'(paddr[spm_pkg::AddrW-1:2]);
	assign wval   = pwdata[spm_pkg::CfgW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks       <= 16'd50;
			cfg_q.pto_timeout_ticks    <= 16'd5000;
			cfg_q.sample_period_ticks  <= 16'd2000;
			cfg_q.liters_per_pulse_q16 <= 16'd239;
			cfg_q.speed_scale_q8       <= 16'd1998;
			cfg_q.moving_threshold_q8  <= 16'd128;
		end else if (wr_en) begin
			unique case (idx)
				spm_pkg::REG_DEBOUNCE:    cfg_q.debounce_ticks       <= wval;
				spm_pkg::REG_PTO_TIMEOUT: cfg_q.pto_timeout_ticks    <= wval;
				spm_pkg::REG_PERIOD:      cfg_q.sample_period_ticks  <= wval;
				spm_pkg::REG_LITERS:      cfg_q.liters_per_pulse_q16 <= wval;
				spm_pkg::REG_SPEED_SCALE: cfg_q.speed_scale_q8       <= wval;
				spm_pkg::REG_MOVING_THR:  cfg_q.moving_threshold_q8  <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			spm_pkg::REG_DEBOUNCE:    rd_val = cfg_q.debounce_ticks;
			spm_pkg::REG_PTO_TIMEOUT: rd_val = cfg_q.pto_timeout_ticks;
			spm_pkg::REG_PERIOD:      rd_val = cfg_q.sample_period_ticks;
			spm_pkg::REG_LITERS:      rd_val = cfg_q.liters_per_pulse_q16;
			spm_pkg::REG_SPEED_SCALE: rd_val = cfg_q.speed_scale_q8;
			spm_pkg::REG_MOVING_THR:  rd_val = cfg_q.moving_threshold_q8;
			default:                  rd_val = '0;
		endcase
	end

	assign prdata = spm_pkg::DataW'(rd_val);
	assign cfg    = cfg_q;

endmodule

>>> rtl/core/spm_tick.sv
`timescale 1ns / 1ps
// spm_tick: per-tick edge detection, pulse counters, timers and sample snapshot.
// Depends on spm_pkg.

module spm_tick (
	input  logic           clk,
	input  logic           arst_n,
	input  spm_pkg::cfg_t  cfg,
	input  logic           tick_valid,
	output logic           tick_ready,
	input  spm_pkg::tick_t tick,
	input  logic           take,
	output logic           snap_valid,
	output spm_pkg::snap_t snap
);

	logic [3:0]                prev_q;
	logic [spm_pkg::CntW-1:0]  flow_q, left_q, right_q, flow_at_q, avg_at_q;
	logic [spm_pkg::TickW-1:0] since_flow_q, since_pto_q, timer_q;
	logic                      snap_valid_s1;
	spm_pkg::snap_t            snap_s1;

	logic [3:0]                lv, rise, fall;
	logic                      xfer, flow_ok, emit;
	logic [spm_pkg::CntW-1:0]  flow_n, left_n, right_n, avg_n;
	logic [spm_pkg::SumW-1:0]  sum_n;
	logic [spm_pkg::TickW-1:0] since_flow_n, since_pto_n, timer_p1;

	assign lv   = {tick.pto_level, tick.nut_right_level, tick.nut_left_level, tick.flow_level};
	assign rise = lv & ~prev_q;
	assign fall = ~lv & prev_q;

	assign flow_ok = fall[0] && (since_flow_q > cfg.debounce_ticks);
	assign flow_n  = flow_q + spm_pkg::CntW'(flow_ok);
	assign left_n  = left_q + spm_pkg::CntW'(rise[1]);
	assign right_n = right_q + spm_pkg::CntW'(rise[2]);

	assign since_flow_n = flow_ok ? '0 :
		(since_flow_q == spm_pkg::TickSat) ? since_flow_q :
		since_flow_q + spm_pkg::TickW'(1);
	assign since_pto_n = rise[3] ? '0 :
		(since_pto_q == spm_pkg::TickSat) ? since_pto_q :
		since_pto_q + spm_pkg::TickW'(1);

	// timer stays below the period, so the increment cannot overflow
	assign timer_p1 = timer_q + spm_pkg::TickW'(1);
	assign emit     = timer_p1 >= cfg.sample_period_ticks;

	assign sum_n = spm_pkg::SumW'(left_n) + spm_pkg::SumW'(right_n);
	assign avg_n = sum_n[spm_pkg::SumW-1:1];

	assign tick_ready = !emit || !snap_valid_s1 || take;
	assign xfer       = tick_valid && tick_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q        <= 4'hF;
			flow_q        <= '0;
			left_q        <= '0;
			right_q       <= '0;
			since_flow_q  <= '0;
			since_pto_q   <= '0;
			timer_q       <= '0;
			flow_at_q     <= '0;
			avg_at_q      <= '0;
			snap_valid_s1 <= 1'b0;
		end else begin
			if (xfer) begin
				prev_q       <= lv;
				flow_q       <= flow_n;
				left_q       <= left_n;
				right_q      <= right_n;
				since_flow_q <= since_flow_n;
				since_pto_q  <= since_pto_n;
				timer_q      <= emit ? '0 : timer_p1;
				if (emit) begin
					flow_at_q <= flow_n;
					avg_at_q  <= avg_n;
				end
			end
			if (xfer && emit) begin
				snap_valid_s1 <= 1'b1;
			end else if (take) begin
				snap_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && emit) begin
			snap_s1.flow_total  <= flow_n;
			snap_s1.left_total  <= left_n;
			snap_s1.right_total <= right_n;
			snap_s1.sum         <= sum_n;
			snap_s1.dflow       <= flow_n - flow_at_q;
			snap_s1.davg        <= avg_n - avg_at_q;
			snap_s1.pto         <= since_pto_n < cfg.pto_timeout_ticks;
		end
	end

	assign snap_valid = snap_valid_s1;
	assign snap       = snap_s1;

endmodule

>>> rtl/core/spm_report.sv
`timescale 1ns / 1ps
// spm_report: liters and speed products, state priority and the status register.
// Depends on spm_pkg.

module spm_report (
	input  logic             clk,
	input  logic             arst_n,
	input  spm_pkg::cfg_t    cfg,
	input  logic             snap_valid,
	input  spm_pkg::snap_t   snap,
	output logic             take,
	output logic             status_valid,
	input  logic             status_ready,
	output spm_pkg::status_t status
);

	logic                        valid_q;
	spm_pkg::status_t            status_q;
	logic [spm_pkg::ProdW-1:0]   liters, speed_full;
	logic [spm_pkg::SpeedW-1:0]  speed;
	spm_pkg::state_t             st;

	assign liters     = spm_pkg::ProdW'(snap.flow_total) *
		spm_pkg::ProdW'(cfg.liters_per_pulse_q16);
	assign speed_full = spm_pkg::ProdW'(snap.davg) * spm_pkg::ProdW'(cfg.speed_scale_q8);
	assign speed      = (speed_full > spm_pkg::ProdW'(spm_pkg::SpeedMax)) ?
		spm_pkg::SpeedMax : speed_full[spm_pkg::SpeedW-1:0];

	always_comb begin
		st = spm_pkg::ST_IDLE;
		if (snap.pto && (speed > spm_pkg::SpeedW'(cfg.moving_threshold_q8))) begin
			st = (snap.dflow != '0) ? spm_pkg::ST_SPRAYING : spm_pkg::ST_MOVING;
		end
		if (snap.pto && (snap.dflow == '0)) begin
			st = spm_pkg::ST_FLOW_FAULT;
		end
		if (snap.left_total == '0) begin
			st = spm_pkg::ST_LEFT_FAULT;
		end
		if (snap.right_total == '0) begin
			st = spm_pkg::ST_RIGHT_FAULT;
		end
	end

	assign take = !valid_q || status_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && snap_valid) begin
			status_q.total_liters_q16 <= 48'(liters);
			status_q.pto_active       <= snap.pto;
			status_q.left_count       <= 32'(snap.left_total);
			status_q.right_count      <= 32'(snap.right_total);
			status_q.count_sum        <= 33'(snap.sum);
			status_q.wheel_speed_q8   <= speed;
			status_q.flow_in_period   <= 32'(snap.dflow);
			status_q.state_code       <= st;
		end
	end

	assign status_valid = valid_q;
	assign status       = status_q;

endmodule

>>> rtl/core/sprayer_sensor_pulse_monitor.sv
`timescale 1ns / 1ps
// Sprayer sensor pulse monitor: one tick per cycle, status every sample period.
// A sample tick's status goes through the snapshot register, then the status register.
// Throughput: 1 tick per cycle; ticks stall only while a status waits in both
// the snapshot and status registers. Reset (arst_n low, async) clears counters
// and timers, sets previous pin levels high and loads register defaults.
// Depends on spm_pkg, spm_regs, spm_tick, spm_report.

module sprayer_sensor_pulse_monitor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [spm_pkg::AddrW-1:0] paddr,
	input  logic [spm_pkg::DataW-1:0] pwdata,
	output logic [spm_pkg::DataW-1:0] prdata,
	output logic                      pready,
	input  logic                      tick_valid,
	output logic                      tick_ready,
	input  spm_pkg::tick_t            tick,
	output logic                      status_valid,
	input  logic                      status_ready,
	output spm_pkg::status_t          status
);

	spm_pkg::cfg_t  cfg;
	spm_pkg::snap_t snap;
	logic           snap_valid;
	logic           take;

	spm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spm_tick u_tick (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.take       (take),
		.snap_valid (snap_valid),
		.snap       (snap)
	);

	spm_report u_report (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.snap_valid   (snap_valid),
		.snap         (snap),
		.take         (take),
		.status_valid (status_valid),
		.status_ready (status_ready),
		.status       (status)
	);

endmodule

>>> rtl/core/spm_checker.sv
`timescale 1ns / 1ps
// spm_checker: port-level assertions for the pulse monitor, bound to the top.
// Depends on spm_pkg and sprayer_sensor_pulse_monitor.

module spm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             pready,
	input logic             status_valid,
	input logic             status_ready,
	input spm_pkg::status_t status
);

	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> status_valid && $stable(status))
		else $error("status changed while stalled");

	a_never_moving: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> status.state_code != spm_pkg::ST_MOVING)
		else $error("moving state reported");

	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> status.count_sum ==
			(33'(status.left_count) + 33'(status.right_count)))
		else $error("count_sum mismatch");

	a_nut_fault: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && (status.right_count == '0) |->
			status.state_code == spm_pkg::ST_RIGHT_FAULT)
		else $error("missing right nut fault");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind sprayer_sensor_pulse_monitor spm_checker u_spm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.status_valid (status_valid),
	.status_ready (status_ready),
	.status       (status)
);
